>>> rtl/ret_pkg.sv
package ret_pkg;

    localparam int VALUE_W     = 48;
    localparam int FRAC_W      = 16;
    localparam int OUT_COUNT_W = 7;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;

    localparam logic signed [VALUE_W-1:0] POS_INF = {1'b0, {(VALUE_W-1){1'b1}}};
    localparam logic signed [VALUE_W-1:0] NEG_INF = {1'b1, {(VALUE_W-1){1'b0}}};
    localparam logic [VALUE_W-1:0] WHOLE_MASK = {{(VALUE_W-FRAC_W){1'b1}}, {FRAC_W{1'b0}}};

    typedef logic signed [VALUE_W-1:0] value_t;

    typedef struct packed {
        logic [1:0] op;
        value_t     value;
        logic       value_is_fraction;
    } in_t;

    typedef struct packed {
        value_t                 extreme_value;
        logic                   result_is_fraction;
        logic                   is_empty;
        logic                   removal_matched;
        logic                   insert_dropped;
        logic [OUT_COUNT_W-1:0] stored_count;
    } out_t;

    // Command broadcast to every cell of the row for one update.
    typedef struct packed {
        logic   insert;
        logic   remove;
        logic   clear;
        value_t value;
    } cell_cmd_t;

endpackage

>>> rtl/ret_cell.sv
module ret_cell (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              exec,
    input  ret_pkg::cell_cmd_t cmd,
    input  logic              prev_gt,
    input  ret_pkg::value_t   prev_value,
    input  logic              prev_valid,
    input  ret_pkg::value_t   next_value,
    input  logic              next_valid,
    input  logic              match_any,
    output ret_pkg::value_t   value,
    output logic              valid,
    output logic              gt,
    output logic              match
);
    import ret_pkg::*;

    value_t value_reg;
    value_t value_next;
    logic   valid_reg;
    logic   valid_next;
    logic   lt;
    logic   eq;

    assign lt    = value_reg < cmd.value;
    assign eq    = value_reg == cmd.value;
    // Empty cells count as greater so the insert point is the first such cell.
    assign gt    = !valid_reg || (!lt && !eq);
    assign match = valid_reg && eq;

    always_comb
    begin
        value_next = value_reg;
        valid_next = valid_reg;
        if (exec)
        begin
            if (cmd.clear)
            begin
                valid_next = 1'b0;
            end
            else if (cmd.insert && gt)
            begin
                if (prev_gt)
                begin
                    // shift up from the left neighbor
                    value_next = prev_value;
                    valid_next = prev_valid;
                end
                else
                begin
                    value_next = cmd.value;
                    valid_next = 1'b1;
                end
            end
            else if (cmd.remove && match_any && (!valid_reg || !lt))
            begin
                // close the gap from the right neighbor
                value_next = next_value;
                valid_next = next_valid;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;
    assign valid = valid_reg;

endmodule

>>> rtl/ret_chain.sv
module ret_chain #(
    parameter int CAPACITY = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               exec,
    input  ret_pkg::cell_cmd_t cmd,
    output logic               match_any,
    output ret_pkg::value_t    head_value,
    output ret_pkg::value_t    tail_value
);
    import ret_pkg::*;

    value_t              cell_value [CAPACITY];
    logic [CAPACITY-1:0] cell_valid;
    logic [CAPACITY-1:0] cell_gt;
    logic [CAPACITY-1:0] cell_match;

    genvar i;
    generate
        for (i = 0; i < CAPACITY; i++)
        begin : g_cell
            logic   prev_gt_w;
            value_t prev_value_w;
            logic   prev_valid_w;
            value_t next_value_w;
            logic   next_valid_w;

            if (i == 0)
            begin : g_first
                assign prev_gt_w    = 1'b0;
                assign prev_value_w = cmd.value;
                assign prev_valid_w = 1'b0;
            end
            else
            begin : g_mid
                assign prev_gt_w    = cell_gt[i-1];
                assign prev_value_w = cell_value[i-1];
                assign prev_valid_w = cell_valid[i-1];
            end

            if (i == CAPACITY - 1)
            begin : g_last
                assign next_value_w = cmd.value;
                assign next_valid_w = 1'b0;
            end
            else
            begin : g_inner
                assign next_value_w = cell_value[i+1];
                assign next_valid_w = cell_valid[i+1];
            end

            ret_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .exec       (exec),
                .cmd        (cmd),
                .prev_gt    (prev_gt_w),
                .prev_value (prev_value_w),
                .prev_valid (prev_valid_w),
                .next_value (next_value_w),
                .next_valid (next_valid_w),
                .match_any  (match_any),
                .value      (cell_value[i]),
                .valid      (cell_valid[i]),
                .gt         (cell_gt[i]),
                .match      (cell_match[i])
            );
        end
    endgenerate

    assign match_any  = |cell_match;
    assign head_value = cell_value[0];

    // Row is sorted ascending and packed low: the last occupied cell is the largest.
    always_comb
    begin
        tail_value = '0;
        for (int k = 0; k < CAPACITY; k++)
        begin
            if (cell_valid[k] && (k == CAPACITY - 1 || !cell_valid[(k + 1) % CAPACITY]))
            begin
                tail_value = tail_value | cell_value[k];
            end
        end
    end

endmodule

>>> rtl/removable_extreme_tracker.sv
// Channel   Direction  Handshake                Payload
// in        input      in_valid / in_ready      ret_pkg::in_t  (op, value, value_is_fraction)
// out       output     out_valid / out_ready    ret_pkg::out_t (extreme, flags, count)
// cfg       input      cfg_valid / cfg_ready    find_largest (1 bit)
//
// Each input transaction first updates the sorted cell row
// (insert, remove or clear in a single shift step), then reads the head or
// tail cell into the output register. The next transaction is taken in the
// read step, so none is taken while the row update is under way.
// Reset empties the row at once (valid bits only) and clears the sticky flag.
// A stalled output holds the result and keeps the block in the read cycle.
module removable_extreme_tracker #(
    parameter int CAPACITY = 64
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  ret_pkg::in_t  in_data,
    output logic          out_valid,
    input  logic          out_ready,
    output ret_pkg::out_t out_data,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic          cfg_data
);
    import ret_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_EMIT = 2'd2;

    logic [1:0]       state_reg;
    logic [1:0]       state_next;
    in_t              item_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             frac_reg;
    logic             frac_next;
    logic             matched_reg;
    logic             matched_next;
    logic             dropped_reg;
    logic             dropped_next;
    logic             largest_reg;
    logic             out_valid_reg;
    logic             out_valid_next;
    out_t             out_data_reg;
    out_t             out_data_next;

    logic             accept;
    logic             slot_free;
    logic             exec;
    logic             full;
    cell_cmd_t        cmd;
    logic             match_any;
    value_t           head_value;
    value_t           tail_value;
    value_t           best;
    value_t           best_mag;
    value_t           extreme;
    logic [CNT_W+OUT_COUNT_W-1:0] count_wide;

    assign slot_free = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE) || (state_reg == S_EMIT && slot_free);
    assign accept    = in_valid && in_ready;
    assign cfg_ready = 1'b1;
    assign exec      = (state_reg == S_EXEC);
    assign full      = (count_reg == CNT_W'(CAPACITY));

    // Decode the held transaction into a row command; drop inserts when full.
    always_comb
    begin
        cmd        = '0;
        cmd.value  = item_reg.value;
        unique case (item_reg.op)
            OP_INSERT: cmd.insert = !full;
            OP_REMOVE: cmd.remove = 1'b1;
            OP_CLEAR:  cmd.clear  = 1'b1;
            default:   cmd        = '0;
        endcase
        cmd.value = item_reg.value;
    end

    ret_chain #(
        .CAPACITY (CAPACITY)
    ) u_chain (
        .clk        (clk),
        .rst_n      (rst_n),
        .exec       (exec),
        .cmd        (cmd),
        .match_any  (match_any),
        .head_value (head_value),
        .tail_value (tail_value)
    );

    // Bookkeeping alongside the row update.
    always_comb
    begin
        count_next   = count_reg;
        frac_next    = frac_reg;
        matched_next = matched_reg;
        dropped_next = dropped_reg;
        if (exec)
        begin
            matched_next = cmd.remove && match_any;
            dropped_next = (item_reg.op == OP_INSERT) && full;
            if (cmd.clear)
            begin
                count_next = '0;
                frac_next  = 1'b0;
            end
            else if (cmd.insert)
            begin
                count_next = count_reg + CNT_W'(1);
                frac_next  = frac_reg || item_reg.value_is_fraction;
            end
            else if (cmd.remove && match_any)
            begin
                count_next = count_reg - CNT_W'(1);
            end
        end
    end

    // Result: pick head or tail, apply the empty rule and whole-number truncation.
    always_comb
    begin
        best     = largest_reg ? tail_value : head_value;
        best_mag = best[VALUE_W-1] ? -best : best;
        best_mag = best_mag & WHOLE_MASK;
        if (count_reg == '0)
        begin
            if (!frac_reg)
            begin
                extreme = '0;
            end
            else
            begin
                extreme = largest_reg ? NEG_INF : POS_INF;
            end
        end
        else if (frac_reg)
        begin
            extreme = best;
        end
        else
        begin
            extreme = best[VALUE_W-1] ? -best_mag : best_mag;
        end
    end

    assign count_wide = {{OUT_COUNT_W{1'b0}}, count_reg};

    always_comb
    begin
        out_data_next                    = out_data_reg;
        out_data_next.extreme_value      = extreme;
        out_data_next.result_is_fraction = frac_reg;
        out_data_next.is_empty           = (count_reg == '0);
        out_data_next.removal_matched    = matched_reg;
        out_data_next.insert_dropped     = dropped_reg;
        out_data_next.stored_count       = count_wide[OUT_COUNT_W-1:0];
    end

    // Sequencer: take, update the row, then load the output register.
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = accept ? S_EXEC : S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            frac_reg      <= 1'b0;
            matched_reg   <= 1'b0;
            dropped_reg   <= 1'b0;
            largest_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            frac_reg      <= frac_next;
            matched_reg   <= matched_next;
            dropped_reg   <= dropped_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                largest_reg <= cfg_data;
            end
        end
    end

    // Payload registers: hold the transaction and the pending result.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= in_data;
        end
        if (state_reg == S_EMIT && slot_free)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

>>> bench/ret_tb_pkg.sv
`timescale 1ns / 100ps

package ret_tb_pkg;

    import ret_pkg::*;

    localparam int CAPACITY = 64;

    // Op code with no function; the block reports its state unchanged.
    localparam logic [1:0] OP_UNUSED = 2'd3;

    class extreme_scoreboard;

        value_t held[$];
        logic   frac_seen;
        logic   find_largest;
        out_t   expected_results[$];
        int     errors;

        function new();
            frac_seen    = 1'b0;
            find_largest = 1'b0;
            errors       = 0;
        endfunction

        function void set_mode(logic mode);
            find_largest = mode;
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        function int held_count();
            return held.size();
        endfunction

        function value_t any_held();
            if (held.size() == 0)
                return '0;
            return held[$urandom_range(0, held.size() - 1)];
        endfunction

        function int error_count();
            return errors;
        endfunction

        // Apply one accepted transaction to the multiset and queue its result.
        function void note_item(in_t item);
            out_t               res;
            value_t             best;
            logic [VALUE_W-1:0] mag;
            int                 hit;
            res = '0;
            hit = -1;
            case (item.op)
                OP_INSERT:
                    if (held.size() >= CAPACITY)
                        res.insert_dropped = 1'b1;
                    else
                    begin
                        held.push_back(item.value);
                        if (item.value_is_fraction)
                            frac_seen = 1'b1;
                    end
                OP_REMOVE:
                begin
                    for (int i = 0; i < held.size() && hit < 0; i++)
                        if (held[i] == item.value)
                            hit = i;
                    if (hit >= 0)
                    begin
                        held.delete(hit);
                        res.removal_matched = 1'b1;
                    end
                end
                OP_CLEAR:
                begin
                    held.delete();
                    frac_seen = 1'b0;
                end
                default: ;
            endcase

            if (held.size() == 0)
                best = frac_seen ? (find_largest ? NEG_INF : POS_INF) : '0;
            else
            begin
                best = held[0];
                foreach (held[i])
                    if (find_largest ? held[i] > best : held[i] < best)
                        best = held[i];
                // integer results drop the fraction, rounding toward zero
                if (!frac_seen)
                begin
                    if (best >= 0)
                        best = best & WHOLE_MASK;
                    else
                    begin
                        mag  = value_t'(-best) & WHOLE_MASK;
                        best = -mag;
                    end
                end
            end

            res.extreme_value      = best;
            res.result_is_fraction = frac_seen;
            res.is_empty           = (held.size() == 0);
            res.stored_count       = OUT_COUNT_W'(held.size());
            expected_results.push_back(res);
        endfunction

        task report(string field, logic [VALUE_W-1:0] got, logic [VALUE_W-1:0] want);
            errors++;
            if (errors <= 30)
                $display("tb: %s: got %h, expected %h", field, got, want);
        endtask

        task check_result(out_t got);
            out_t want;
            if (expected_results.size() == 0)
            begin
                report("result with nothing pending", got.extreme_value, '0);
                return;
            end
            want = expected_results.pop_front();
            if (got.extreme_value !== want.extreme_value)
                report("extreme_value", got.extreme_value, want.extreme_value);
            if (got.result_is_fraction !== want.result_is_fraction)
                report("result_is_fraction", got.result_is_fraction, want.result_is_fraction);
            if (got.is_empty !== want.is_empty)
                report("is_empty", got.is_empty, want.is_empty);
            if (got.removal_matched !== want.removal_matched)
                report("removal_matched", got.removal_matched, want.removal_matched);
            if (got.insert_dropped !== want.insert_dropped)
                report("insert_dropped", got.insert_dropped, want.insert_dropped);
            if (got.stored_count !== want.stored_count)
                report("stored_count", got.stored_count, want.stored_count);
        endtask

    endclass

endpackage

>>> bench/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

    import ret_pkg::*;
    import ret_tb_pkg::*;

    // cycles with no transaction on any channel before the run is declared hung
    localparam int IDLE_LIMIT   = 2000;
    localparam int PHASES       = 6;
    localparam int PHASE_ITEMS  = 305;
    // settle time after the last result
    localparam int DRAIN_CYCLES = 8;

    logic   clk;
    logic   rst_n;
    logic   in_valid;
    logic   in_ready;
    in_t    in_data;
    logic   out_valid;
    logic   out_ready;
    out_t   out_data;
    logic   cfg_valid;
    logic   cfg_ready;
    logic   cfg_data;

    // when set, neither side idles
    logic   steady;
    int     items_sent;
    int     stall_cycles;
    // values that random items favor, so removes find matches and ties occur
    value_t pool[8];

    extreme_scoreboard sb = new();

    removable_extreme_tracker #(
        .CAPACITY (CAPACITY)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // Observe every channel at the clock edge. Check the result first: a result
    // taken at this edge always belongs to an earlier input transaction.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
                sb.check_result(out_data);
            if (in_valid && in_ready)
                sb.note_item(in_data);
            if (cfg_valid && cfg_ready)
                sb.set_mode(cfg_data);
        end
    end

    // Watchdog: restart the count on any transaction, give up at the limit.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
            || (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= IDLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // Mostly no gap, often a short one, now and then a long one.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (steady)
            return 0;
        if (r < 65)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic value_t rand_word();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[VALUE_W-1:0];
    endfunction

    // Operand for inserts: pool entries, full-range words, small whole
    // numbers, small values with fraction bits, and copies of stored values.
    function automatic value_t pick_value();
        value_t v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: v = pool[$urandom_range(0, 7)];
            4, 5:       v = rand_word();
            6:          v = (value_t'($urandom_range(0, 40)) - 20) * 65536;
            7:          v = value_t'($urandom_range(0, 1 << 20)) - (1 << 19);
            default:    v = sb.held_count() > 0 ? sb.any_held() : rand_word();
        endcase
        return v;
    endfunction

    // Operand for removes: mostly a stored value, sometimes one bit off it.
    function automatic value_t remove_operand();
        value_t v;
        int     r;
        r = $urandom_range(0, 9);
        if (sb.held_count() == 0 || r > 7)
            v = pick_value();
        else
            v = sb.any_held();
        if (r == 7 && sb.held_count() > 0)
            v ^= value_t'(1) << $urandom_range(0, VALUE_W - 1);
        return v;
    endfunction

    // Send one input transaction: hold valid and payload until it is taken.
    // Valid is lowered only for a gap, so back-to-back items keep it high.
    task automatic drive(input logic [1:0] code, input value_t operand, input logic frac);
        int gap;
        gap = gap_len();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= '{op: code, value: operand, value_is_fraction: frac};
        do @(posedge clk); while (!in_ready);
        if (code != OP_UNUSED)
            items_sent++;
    endtask

    // Drop valid, wait until every pending result is back, then write the mode.
    task automatic write_mode(input logic mode);
        in_valid <= 1'b0;
        do @(posedge clk); while (sb.pending() != 0);
        cfg_valid <= 1'b1;
        cfg_data  <= mode;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // Random traffic built from runs: fill bursts that overflow the store,
    // drains that empty it, mixed insert/remove runs, clears and raw noise.
    task automatic run_phase(input int target);
        int first;
        int n;
        int r;
        first = items_sent;
        while (items_sent - first < target)
        begin
            case ($urandom_range(0, 9))
                0:
                begin
                    n = $urandom_range(50, 72);
                    repeat (n)
                        drive(OP_INSERT, pick_value(), $urandom_range(0, 15) == 0);
                end
                7:
                begin
                    n = sb.held_count();
                    repeat (n)
                        drive(OP_REMOVE, sb.any_held(), 1'($urandom_range(0, 1)));
                end
                8:
                    drive(OP_CLEAR, rand_word(), 1'($urandom_range(0, 1)));
                9:
                    repeat ($urandom_range(5, 15))
                        drive(2'($urandom_range(0, 3)), rand_word(),
                              1'($urandom_range(0, 1)));
                default:
                    repeat ($urandom_range(10, 30))
                    begin
                        r = $urandom_range(0, 99);
                        if (r < 46)
                            drive(OP_INSERT, pick_value(), $urandom_range(0, 15) == 0);
                        else if (r < 88)
                            drive(OP_REMOVE, remove_operand(), 1'($urandom_range(0, 1)));
                        else if (r < 92)
                            drive(OP_CLEAR, rand_word(), 1'($urandom_range(0, 1)));
                        else
                            drive(OP_UNUSED, rand_word(), 1'($urandom_range(0, 1)));
                    end
            endcase
        end
    endtask

    // Result side: ready in runs, broken by gaps of random length.
    initial
    begin : ready_driver
        int run;
        int gap;
        wait (rst_n === 1'b1);
        forever
        begin
            out_ready <= 1'b1;
            run = $urandom_range(1, 12);
            repeat (run) @(posedge clk);
            gap = gap_len();
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    end

    initial
    begin
        clk          = 1'b0;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        in_data      = '0;
        out_ready    = 1'b0;
        cfg_valid    = 1'b0;
        cfg_data     = 1'b0;
        steady       = 1'b0;
        items_sent   = 0;
        stall_cycles = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part, smallest-value mode as after reset.
        drive(OP_REMOVE, 48'sd5, 1'b0);             // remove from an empty store
        drive(OP_UNUSED, 48'sd77, 1'b1);            // unused op must not set the flag
        drive(OP_INSERT, POS_INF, 1'b0);            // largest value, fraction dropped
        drive(OP_INSERT, NEG_INF, 1'b0);            // least value
        drive(OP_INSERT, -48'sd1, 1'b0);            // tiny negative truncates to zero
        drive(OP_INSERT, 48'sd98304, 1'b0);         // 1.5
        drive(OP_REMOVE, NEG_INF, 1'b0);            // minimum now truncates to zero
        drive(OP_INSERT, -48'sd98304, 1'b0);        // -1.5 reads as -1
        drive(OP_INSERT, -48'sd98304, 1'b0);        // duplicate copy
        drive(OP_REMOVE, -48'sd98304, 1'b0);        // only one copy goes
        drive(OP_REMOVE, POS_INF - 1, 1'b0);        // differs in the last bit: no match
        drive(OP_INSERT, 48'sd147456, 1'b1);        // flag set, exact -1.5 reported
        drive(OP_UNUSED, rand_word(), 1'b1);
        drive(OP_CLEAR, 48'sd0, 1'b1);              // clear also drops the flag
        drive(OP_INSERT, 48'sd196608, 1'b1);
        drive(OP_REMOVE, 48'sd196608, 1'b0);        // empty with flag: positive infinity

        // Largest-value mode, store empty with the flag still set.
        write_mode(1'b1);
        drive(OP_UNUSED, 48'sd0, 1'b0);             // negative infinity
        drive(OP_INSERT, 48'sd491520, 1'b0);        // 7.5, flag still set
        drive(OP_INSERT, -48'sh123456789ABC, 1'b0);
        drive(OP_CLEAR, 48'sd0, 1'b0);              // empty with flag clear reads 0
        drive(OP_INSERT, -48'sd376832, 1'b0);       // -5.75 reads as -5
        drive(OP_INSERT, -48'sd32768, 1'b0);        // -0.5 reads as 0
        drive(OP_CLEAR, 48'sd0, 1'b0);

        // Random phases; alternate the mode, and run one phase with no idling.
        for (int ph = 0; ph < PHASES; ph++)
        begin
            steady  = (ph == 3);
            pool[0] = POS_INF;
            pool[1] = NEG_INF;
            pool[2] = '0;
            pool[3] = -1;
            pool[4] = 65536;
            for (int k = 5; k < 8; k++)
                pool[k] = rand_word();
            write_mode(1'(ph % 2));
            run_phase(PHASE_ITEMS);
        end

        // Drain: wait for every pending result, then let the block settle.
        in_valid <= 1'b0;
        do @(posedge clk); while (sb.pending() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.error_count() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
